FILE: rtl/tslp_pkg.sv
package tslp_pkg;

  localparam int unsigned IdW      = 32;
  localparam int unsigned NameLenW = 5;
  localparam int unsigned NameSlots = 16;

  // Saturation point of the id magnitude (2^31).
  localparam logic [IdW-1:0] IdSat    = 32'h8000_0000;
  localparam logic [IdW-1:0] IdPosMax = 32'h7FFF_FFFF;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [2:0] {
    PH_ID         = 3'd0,
    PH_NAME_START = 3'd1,
    PH_NAME       = 3'd2,
    PH_NAME_END   = 3'd3,
    PH_STATUS     = 3'd4,
    PH_DONE       = 3'd5
  } parse_phase_e;

  typedef enum logic [3:0] {
    STC_RUNNING  = 4'd0,
    STC_SLEEPING = 4'd1,
    STC_DISK     = 4'd2,
    STC_STOPPED  = 4'd3,
    STC_TRACED   = 4'd4,
    STC_DEAD     = 4'd5,
    STC_ZOMBIE   = 4'd6,
    STC_PARKED   = 4'd7,
    STC_IDLE     = 4'd8,
    STC_UNKNOWN  = 4'd9
  } state_code_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       record_end;
  } in_word_t;

  typedef struct packed {
    logic                 parse_ok;
    logic signed [IdW-1:0] thread_id;
    logic [63:0]          name_low_bytes;
    logic [63:0]          name_high_bytes;
    logic [NameLenW-1:0]  name_len;
    state_code_e          state_code;
    logic [7:0]           state_char;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } parse_res_t;

  function automatic state_code_e classify(input logic [7:0] c);
    state_code_e code;
    unique case (c)
      8'h52:   code = STC_RUNNING;   // R
      8'h53:   code = STC_SLEEPING;  // S
      8'h44:   code = STC_DISK;      // D
      8'h54:   code = STC_STOPPED;   // T
      8'h74:   code = STC_TRACED;    // t
      8'h58:   code = STC_DEAD;      // X
      8'h5A:   code = STC_ZOMBIE;    // Z
      8'h50:   code = STC_PARKED;    // P
      8'h49:   code = STC_IDLE;      // I
      default: code = STC_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/task_stat_line_parser_unit.sv
// A word accepted into the input register is parsed when the parser steps on it; that same
// edge also loads its result word, if it has one, into the output register.
// Throughput: one text byte per cycle, back to back; a byte only waits while the output
// register holds a word that the consumer is stalling.
// Reset: asynchronous, active low; the parser returns to the id phase with an
// empty name store, and both pipeline registers come up empty.
module task_stat_line_parser_unit import tslp_pkg::*; #(
  parameter int unsigned NAME_MAX_CHARS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // Input register. A byte is registered here before the parser consumes it.
  logic      in_valid_q, in_valid_d;
  in_word_t  in_word_q;

  // Result register. It decouples the parser from a stalling consumer.
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  logic       out_free;
  logic       step;
  logic       in_accept;
  parse_res_t res;

  // The result register can take a new word when it is empty or being drained this cycle.
  // The parser only steps when it could place a result, so a byte that produces a word is
  // never dropped. Any byte waits in the input register for as long as a full result
  // register is stalled, whether or not it would produce a word.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  tslp_parser #(
    .NAME_MAX_CHARS(NAME_MAX_CHARS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_word_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only when a new word actually enters them.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
    if (step && res.valid) begin
      out_word_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A failure word carries nothing but zeros.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.parse_ok |->
      out_word_o.thread_id == 32'sd0 && out_word_o.name_len == '0 &&
      out_word_o.name_low_bytes == '0 && out_word_o.name_high_bytes == '0 &&
      out_word_o.state_char == '0)
    else $error("failure result carries nonzero fields");

  // The reported name length never exceeds the capture limit.
  a_name_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.name_len <= NameLenW'(NAME_MAX_CHARS))
    else $error("name length beyond capture limit");

  // A success word's code matches its raw state character.
  a_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.parse_ok |->
      out_word_o.state_code == classify(out_word_o.state_char))
    else $error("state code does not match state character");

  // A byte held in the input register is consumed whenever the output side can take a word.
  a_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> !in_valid_q || $past(in_accept))
    else $error("input byte not consumed while output was free");

endmodule

FILE: rtl/tslp_parser.sv
module tslp_parser import tslp_pkg::*; #(
  parameter int unsigned NAME_MAX_CHARS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_word_t   word_i,
  output parse_res_t res_o
);

  parse_phase_e        phase_q, phase_d;
  logic [IdW-1:0]      acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                stopped_q, stopped_d;
  logic                started_q, started_d;
  logic [IdW-1:0]      id_final_q, id_final_d;
  logic [7:0]          name_q [NAME_MAX_CHARS];
  logic [7:0]          name_d [NAME_MAX_CHARS];
  logic [NameLenW-1:0] count_q, count_d;

  logic [7:0]     c;
  logic           last;
  logic [IdW+3:0] acc_x10;
  logic [IdW-1:0] id_value;
  logic           name_we;
  logic           emit_ok;
  logic           emit_fail;
  logic [7:0]     name_bytes [NameSlots];

  assign c    = word_i.text_byte;
  assign last = word_i.record_end;

  // acc * 10 + digit, wide enough that it never wraps before the saturation compare.
  assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, c[3:0]};

  assign id_value = neg_q ? (32'd0 - acc_q) : (acc_q[IdW-1] ? IdPosMax : acc_q);

  assign name_we = (phase_q == PH_NAME) && (c != ChRParen) &&
                   (count_q < NameLenW'(NAME_MAX_CHARS));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_ID:         if (c == ChSpace)  phase_d = PH_NAME_START;
        PH_NAME_START: if (c == ChLParen) phase_d = PH_NAME;
        PH_NAME:       if (c == ChRParen) phase_d = PH_NAME_END;
        PH_NAME_END:   if (c == ChSpace)  phase_d = PH_STATUS;
        PH_STATUS:     phase_d = PH_DONE;
        PH_DONE:       phase_d = PH_DONE;
        default:       phase_d = PH_ID;
      endcase
      if (last) begin
        phase_d = PH_ID;
      end
    end
  end

  // Datapath updates: id accumulation and name capture.
  always_comb begin
    acc_d      = acc_q;
    neg_d      = neg_q;
    stopped_d  = stopped_q;
    started_d  = started_q;
    id_final_d = id_final_q;
    count_d    = count_q;
    for (int k = 0; k < NAME_MAX_CHARS; k++) begin
      name_d[k] = name_q[k];
    end
    if (step_i) begin
      if (phase_q == PH_ID) begin
        if (c == ChSpace) begin
          id_final_d = id_value;
        end else if (!stopped_q) begin
          priority if (c >= ChZero && c <= ChNine) begin
            acc_d     = (acc_x10 > 36'(IdSat)) ? IdSat : acc_x10[IdW-1:0];
            started_d = 1'b1;
          end else if (!started_q && c >= ChTab && c <= ChCr) begin
            // Leading white space is skipped.
          end else if (!started_q && (c == ChPlus || c == ChMinus)) begin
            neg_d     = (c == ChMinus);
            started_d = 1'b1;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
      if (name_we) begin
        for (int k = 0; k < NAME_MAX_CHARS; k++) begin
          if (count_q == NameLenW'(k)) begin
            name_d[k] = c;
          end
        end
        count_d = count_q + NameLenW'(1);
      end
      if (last) begin
        acc_d      = '0;
        neg_d      = 1'b0;
        stopped_d  = 1'b0;
        started_d  = 1'b0;
        id_final_d = '0;
        count_d    = '0;
        for (int k = 0; k < NAME_MAX_CHARS; k++) begin
          name_d[k] = '0;
        end
      end
    end
  end

  for (genvar g = 0; g < NameSlots; g++) begin : g_name_bytes
    if (g < NAME_MAX_CHARS) begin : g_used
      assign name_bytes[g] = name_q[g];
    end else begin : g_unused
      assign name_bytes[g] = 8'd0;
    end
  end

  // Result forming.
  assign emit_ok   = step_i && (phase_q == PH_STATUS);
  assign emit_fail = step_i && last && (phase_q != PH_STATUS) && (phase_q != PH_DONE);

  always_comb begin
    res_o       = '0;
    res_o.valid = emit_ok || emit_fail;
    if (emit_ok) begin
      res_o.word.parse_ok    = 1'b1;
      res_o.word.thread_id   = id_final_q;
      res_o.word.name_len    = count_q;
      res_o.word.state_code  = classify(c);
      res_o.word.state_char  = c;
      for (int k = 0; k < 8; k++) begin
        res_o.word.name_low_bytes[8*k +: 8]  = name_bytes[k];
        res_o.word.name_high_bytes[8*k +: 8] = name_bytes[k+8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ID;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      stopped_q  <= 1'b0;
      started_q  <= 1'b0;
      id_final_q <= '0;
      count_q    <= '0;
      for (int k = 0; k < NAME_MAX_CHARS; k++) begin
        name_q[k] <= '0;
      end
    end else begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      stopped_q  <= stopped_d;
      started_q  <= started_d;
      id_final_q <= id_final_d;
      count_q    <= count_d;
      for (int k = 0; k < NAME_MAX_CHARS; k++) begin
        name_q[k] <= name_d[k];
      end
    end
  end

endmodule
